FILE: rtl/msm_pkg.sv
// Shared types and constants for the row-major matrix store.
// No dependencies; used by the core, the checker and the testbench.
`timescale 1ns / 1ps

package msm_pkg;

  // Width of the row and column count registers.
  localparam int CFG_W = 5;

  // Field widths of one input beat and one result beat.
  localparam int INDEX_W = 16;
  localparam int VALUE_W = 32;
  localparam int MAXI_W  = 16;
  localparam int FRAC_W  = 16;

  // Packed widths on the stream ports.
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_SYM   = 2'd2,
    ACT_MAX   = 2'd3
  } action_t;

  typedef enum logic {
    REG_ROW_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } cfg_reg_t;

endpackage

FILE: rtl/msm_ram.sv
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module msm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/matrix_store_symmetry_max_core.sv
// Row-major matrix store of Q16.16 elements with read, write, symmetry check
// and maximum search. Depends on msm_pkg and msm_ram.
// One item at a time; the single memory read port and the shared index
// multiply-add set the pace of the walks.
// Reset clears control state and sets both counts to 16; the store is not cleared.
`timescale 1ns / 1ps

module matrix_store_symmetry_max_core #(
  parameter int MAX_DIM = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic [msm_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [msm_pkg::IN_DATA_W-1:0]    in_tdata,   // row[15:0], col[31:16], value[63:32]
  input  logic [1:0]                       in_tuser,   // action[1:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [msm_pkg::OUT_DATA_W-1:0]   out_tdata   // read_value[31:0], is_symmetric[32],
                                                       // max_integer[48:33], error[49], zero
);

  localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W      = $clog2(MAX_DIM + 1);
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W     = IDX_W + CNT_W + 1;
  localparam int VW         = msm_pkg::VALUE_W;
  localparam int FRAC_SHIFT = msm_pkg::FRAC_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_SYM_A, S_SYM_B, S_SYM_C, S_MX_RUN, S_MX_LAST, S_DONE
  } state_t;

  state_t                      state_r, state_nxt;
  logic [msm_pkg::CFG_W-1:0]   row_count_r, column_count_r;
  logic [IDX_W-1:0]            i_r, i_nxt, j_r, j_nxt;
  logic [VW-1:0]               a_r, a_nxt;
  logic [VW-1:0]               best_r, best_nxt;
  logic                        pend_r, pend_nxt;
  logic                        first_r, first_nxt;
  logic [VW-1:0]               res_read_r, res_read_nxt;
  logic                        res_sym_r, res_sym_nxt;
  logic [msm_pkg::MAXI_W-1:0]  res_max_r, res_max_nxt;
  logic                        res_err_r, res_err_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [VW-1:0]               out_read_r, out_read_nxt;
  logic                        out_sym_r, out_sym_nxt;
  logic [msm_pkg::MAXI_W-1:0]  out_max_r, out_max_nxt;
  logic                        out_err_r, out_err_nxt;

  logic [CNT_W-1:0]            nr, nc;
  logic [msm_pkg::INDEX_W-1:0] in_row, in_col;
  logic [VW-1:0]               in_value;
  msm_pkg::action_t            in_action;
  logic                        accept, in_bounds;
  logic [IDX_W-1:0]            ra, ca;
  logic [PROD_W-1:0]           addr_full;
  logic [ADDR_W-1:0]           addr;
  logic                        ram_we;
  logic [VW-1:0]               rd_data;
  logic [VW-1:0]               best_now;
  logic                        row_end, col_end;
  logic [msm_pkg::MAXI_W-1:0]  trunc_val;

  assign in_row    = in_tdata[15:0];
  assign in_col    = in_tdata[31:16];
  assign in_value  = in_tdata[63:32];
  assign in_action = msm_pkg::action_t'(in_tuser);

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    nr = (int'(row_count_r) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(row_count_r);
    nc = (int'(column_count_r) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(column_count_r);
  end

  assign in_bounds = !in_row[15] && !in_col[15] &&
                     (32'(in_row[14:0]) < 32'(nr)) && (32'(in_col[14:0]) < 32'(nc));

  // Shared index unit: address = ra * column_count + ca.
  assign addr_full = PROD_W'(ra) * PROD_W'(nc) + PROD_W'(ca);
  assign addr      = addr_full[ADDR_W-1:0];
  assign ram_we    = accept && (in_action == msm_pkg::ACT_WRITE) && in_bounds;

  msm_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (in_value),
    .raddr (addr),
    .rdata (rd_data)
  );

  assign row_end = (CNT_W'(i_r) == CNT_W'(nr - CNT_W'(1)));
  assign col_end = (CNT_W'(j_r) == CNT_W'(nc - CNT_W'(1)));

  // Running maximum including the element that arrives this cycle.
  always_comb begin
    if (first_r || ($signed(rd_data) > $signed(best_r))) begin
      best_now = rd_data;
    end else begin
      best_now = best_r;
    end
  end

  // Integer part toward zero: a negative value with a fraction rounds up.
  assign trunc_val = best_now[VW-1:FRAC_SHIFT] +
                     msm_pkg::MAXI_W'(best_now[VW-1] && (best_now[FRAC_SHIFT-1:0] != '0));

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    a_nxt         = a_r;
    best_nxt      = best_r;
    pend_nxt      = pend_r;
    first_nxt     = first_r;
    res_read_nxt  = res_read_r;
    res_sym_nxt   = res_sym_r;
    res_max_nxt   = res_max_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r;
    out_read_nxt  = out_read_r;
    out_sym_nxt   = out_sym_r;
    out_max_nxt   = out_max_r;
    out_err_nxt   = out_err_r;
    ra            = i_r;
    ca            = j_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        ra = in_row[IDX_W-1:0];
        ca = in_col[IDX_W-1:0];
        if (accept) begin
          res_read_nxt = '0;
          res_sym_nxt  = 1'b0;
          res_max_nxt  = '0;
          res_err_nxt  = 1'b0;
          state_nxt    = S_DONE;
          case (in_action)
            msm_pkg::ACT_WRITE: begin
              res_err_nxt = !in_bounds;
            end
            msm_pkg::ACT_READ: begin
              res_err_nxt = !in_bounds;
              if (in_bounds) begin
                state_nxt = S_RD;
              end
            end
            msm_pkg::ACT_SYM: begin
              if (nr != nc) begin
                res_sym_nxt = 1'b0;
              end else if (nr <= CNT_W'(1)) begin
                res_sym_nxt = 1'b1;
              end else begin
                i_nxt     = '0;
                j_nxt     = IDX_W'(1);
                state_nxt = S_SYM_A;
              end
            end
            msm_pkg::ACT_MAX: begin
              if ((nr == '0) || (nc == '0)) begin
                res_err_nxt = 1'b1;
              end else begin
                i_nxt     = '0;
                j_nxt     = '0;
                pend_nxt  = 1'b0;
                first_nxt = 1'b1;
                state_nxt = S_MX_RUN;
              end
            end
            default: begin
              res_err_nxt = 1'b0;
            end
          endcase
        end
      end
      S_RD: begin
        res_read_nxt = rd_data;
        state_nxt    = S_DONE;
      end
      S_SYM_A: begin
        state_nxt = S_SYM_B;
      end
      S_SYM_B: begin
        ra        = j_r;
        ca        = i_r;
        a_nxt     = rd_data;
        state_nxt = S_SYM_C;
      end
      S_SYM_C: begin
        if (rd_data != a_r) begin
          res_sym_nxt = 1'b0;
          state_nxt   = S_DONE;
        end else if (col_end) begin
          if (CNT_W'(i_r) + CNT_W'(2) == nr) begin
            res_sym_nxt = 1'b1;
            state_nxt   = S_DONE;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            j_nxt     = i_r + IDX_W'(2);
            state_nxt = S_SYM_B;
          end
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = S_SYM_B;
        end
        ra = i_nxt;
        ca = j_nxt;
      end
      S_MX_RUN: begin
        if (pend_r) begin
          best_nxt  = best_now;
          first_nxt = 1'b0;
        end
        pend_nxt = 1'b1;
        if (row_end && col_end) begin
          state_nxt = S_MX_LAST;
        end else if (col_end) begin
          i_nxt = i_r + IDX_W'(1);
          j_nxt = '0;
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      S_MX_LAST: begin
        best_nxt    = best_now;
        first_nxt   = 1'b0;
        pend_nxt    = 1'b0;
        res_max_nxt = trunc_val;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_read_nxt  = res_read_r;
          out_sym_nxt   = res_sym_r;
          out_max_nxt   = res_max_r;
          out_err_nxt   = res_err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      row_count_r    <= msm_pkg::CFG_W'(16);
      column_count_r <= msm_pkg::CFG_W'(16);
      i_r            <= '0;
      j_r            <= '0;
      pend_r         <= 1'b0;
      first_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      pend_r      <= pend_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (msm_pkg::cfg_reg_t'(cfg_addr))
          msm_pkg::REG_ROW_COUNT:    row_count_r    <= cfg_wdata;
          msm_pkg::REG_COLUMN_COUNT: column_count_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
    a_r        <= a_nxt;
    best_r     <= best_nxt;
    res_read_r <= res_read_nxt;
    res_sym_r  <= res_sym_nxt;
    res_max_r  <= res_max_nxt;
    res_err_r  <= res_err_nxt;
    out_read_r <= out_read_nxt;
    out_sym_r  <= out_sym_nxt;
    out_max_r  <= out_max_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_err_r, out_max_r, out_sym_r, out_read_r};

  // The symmetry walk only visits pairs above the diagonal.
  a_sym_upper: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SYM_A || state_r == S_SYM_B || state_r == S_SYM_C) |-> (i_r < j_r))
    else $error("symmetry walk left the upper triangle");

  // The maximum walk stays inside the matrix.
  a_max_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MX_RUN) |-> ((CNT_W'(i_r) < nr) && (CNT_W'(j_r) < nc)))
    else $error("maximum walk outside the matrix");

  // An error result carries no symmetry flag and no maximum.
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (!out_sym_r && (out_max_r == '0)))
    else $error("error result carries other fields");

  // A nonzero read value only comes from a good read.
  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_read_r != '0)) |-> (!out_err_r && !out_sym_r && (out_max_r == '0)))
    else $error("read value on a non-read result");

endmodule

FILE: tb/msm_checker.sv
// Result checker for matrix_store_symmetry_max_core: tracks the register writes and
// the accepted request beats, predicts each result beat and compares it field by field.
// Depends on msm_pkg.
`timescale 1ns / 1ps

module msm_checker #(
  parameter int MAX_DIM = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_addr,
  input  logic [msm_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [msm_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                     in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [msm_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             fail_count,
  output int                             pending
);
  import msm_pkg::*;

  // Laid out so that the struct matches the low 50 bits of out_tdata.
  typedef struct packed {
    logic        error;
    logic [15:0] max_integer;
    logic        is_symmetric;
    logic [31:0] read_value;
  } answer_t;

  logic [31:0]      shadow_store [0:MAX_DIM*MAX_DIM-1];
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  answer_t          answers_due [$];

  function automatic answer_t matrix_answer(action_t act, logic signed [15:0] r,
                                            logic signed [15:0] c, logic [31:0] v);
    int               nr;
    int               nc;
    int               k;
    logic signed [31:0] best;
    longint           w;
    bit               in_range;
    answer_t          a;
    a = '0;
    nr = (rows_reg > MAX_DIM) ? MAX_DIM : int'(rows_reg);
    nc = (cols_reg > MAX_DIM) ? MAX_DIM : int'(cols_reg);
    in_range = (r >= 0) && (c >= 0) && (r < nr) && (c < nc);
    k = in_range ? r * nc + c : 0;
    case (act)
      ACT_WRITE: begin
        if (in_range) shadow_store[k] = v;
        else a.error = 1'b1;
      end
      ACT_READ: begin
        if (in_range) a.read_value = shadow_store[k];
        else a.error = 1'b1;
      end
      ACT_SYM: begin
        a.is_symmetric = (nr == nc);
        if (nr == nc) begin
          for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
              if (shadow_store[i*nc+j] !== shadow_store[j*nc+i]) a.is_symmetric = 1'b0;
            end
          end
        end
      end
      default: begin
        if (nr == 0 || nc == 0) begin
          a.error = 1'b1;
        end else begin
          best = shadow_store[0];
          for (int i = 1; i < nr * nc; i++) begin
            if ($signed(shadow_store[i]) > best) best = shadow_store[i];
          end
          w = best;
          if (w < 0) w = -((-w) >>> 16);
          else w = w >>> 16;
          a.max_integer = w[15:0];
        end
      end
    endcase
    return a;
  endfunction

  always @(posedge clk) begin : watch
    answer_t got;
    answer_t want;
    if (!rst_n) begin
      rows_reg = CFG_W'(16);
      cols_reg = CFG_W'(16);
      answers_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_ROW_COUNT:    rows_reg = cfg_wdata;
          REG_COLUMN_COUNT: cols_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[49:0];
        if (answers_due.size() == 0) begin
          $error("result beat %h arrived with no request waiting", out_tdata);
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, got.read_value);
            fail_count++;
          end
          if (got.is_symmetric !== want.is_symmetric) begin
            $error("is_symmetric: expected %b, got %b", want.is_symmetric, got.is_symmetric);
            fail_count++;
          end
          if (got.max_integer !== want.max_integer) begin
            $error("max_integer: expected %h, got %h", want.max_integer, got.max_integer);
            fail_count++;
          end
          if (got.error !== want.error) begin
            $error("error: expected %b, got %b", want.error, got.error);
            fail_count++;
          end
          if (out_tdata[OUT_DATA_W-1:50] !== '0) begin
            $error("padding: expected %h, got %h", 6'h0, out_tdata[OUT_DATA_W-1:50]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        answers_due.push_back(matrix_answer(action_t'(in_tuser), in_tdata[15:0],
                                            in_tdata[31:16], in_tdata[63:32]));
      end
    end
    pending = answers_due.size();
  end

endmodule

FILE: tb/tb.sv
// Top of the matrix_store_symmetry_max_core testbench: clock, reset, register writes,
// request stimulus with bursts and gaps, result back-pressure and the verdict.
// Depends on msm_pkg, the core and msm_checker.
`timescale 1ns / 1ps

module tb;
  import msm_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int HOLD_AT      = 700;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic                  cfg_addr   = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic in_acc_q  = 1'b0;
  bit   hold_req  = 1'b0;
  bit   hold_done = 1'b0;
  int   fail_count;
  int   pending;
  int   nr = 16;
  int   nc = 16;
  int   sent = 0;
  int   burst_left = 0;
  int   phase_rows [0:12];
  int   phase_cols [0:12];

  matrix_store_symmetry_max_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  msm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // The driver looks at this flag on the falling edge to learn that its beat was taken.
  always @(posedge clk) begin
    in_acc_q <= in_tvalid && in_tready;
  end

  function automatic logic [31:0] rand_value(bit neg);
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      2:       v = -$urandom_range(1, 32'h1_FFFF);
      3:       v = $urandom_range(0, 32'h1_FFFF);
      default: v = $urandom;
    endcase
    if (neg && !v[31]) v = ~v;
    return v;
  endfunction

  function automatic logic [15:0] pick_index(int n, bit bad);
    if (!bad) return 16'($urandom_range(0, n - 1));
    case ($urandom_range(0, 5))
      0:       return 16'hFFFF;
      1:       return 16'(n);
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      4:       return 16'(n + $urandom_range(0, 20));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic idle(int n);
    in_tvalid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic push(action_t a, logic [15:0] r, logic [15:0] c, logic [31:0] v);
    if (burst_left == 0) begin
      idle(($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    if (sent == HOLD_AT) hold_req = 1'b1;
    in_tvalid = 1'b1;
    in_tuser  = a;
    in_tdata  = {v, c, r};
    do @(negedge clk); while (!in_acc_q);
    sent++;
  endtask

  task automatic set_dims(int r, int c);
    idle(1);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = REG_ROW_COUNT;
    cfg_wdata = r[CFG_W-1:0];
    @(negedge clk);
    cfg_addr  = REG_COLUMN_COUNT;
    cfg_wdata = c[CFG_W-1:0];
    @(negedge clk);
    cfg_we    = 1'b0;
    nr = (r > 16) ? 16 : r;
    nc = (c > 16) ? 16 : c;
    burst_left = 0;
  endtask

  // Writes every element in use; a square matrix comes out symmetric.
  task automatic refill(bit neg);
    logic [31:0] v;
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        v = rand_value(neg);
        if (nr != nc) begin
          push(ACT_WRITE, 16'(i), 16'(j), v);
        end else if (j >= i) begin
          push(ACT_WRITE, 16'(i), 16'(j), v);
          if (j != i) push(ACT_WRITE, 16'(j), 16'(i), v);
        end
      end
    end
  endtask

  task automatic random_item(bit neg);
    int          pick;
    bit          bad_r;
    bit          bad_c;
    logic [15:0] r;
    logic [15:0] c;
    logic [31:0] v;
    pick = $urandom_range(0, 99);
    v = rand_value(neg);
    if (pick >= 75) begin
      push((pick >= 87) ? ACT_MAX : ACT_SYM, 16'($urandom), 16'($urandom), v);
    end else begin
      bad_r = (nr == 0) || ($urandom_range(0, 19) == 0);
      bad_c = (nc == 0) || ($urandom_range(0, 19) == 0);
      r = pick_index(nr, bad_r);
      c = pick_index(nc, bad_c);
      if (pick < 40) begin
        push(ACT_WRITE, r, c, v);
        if (!bad_r && !bad_c && c < nr && r < nc && $urandom_range(0, 9) < 6)
          push(ACT_WRITE, c, r, v);
      end else begin
        push(ACT_READ, r, c, v);
      end
    end
  endtask

  // Result side: changing stall patterns plus one long hold-off on request.
  initial begin : sink
    int mode;
    int left;
    int hold;
    mode = 0;
    left = 0;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold = 500;
        hold_done = 1'b1;
      end
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(8, 80);
        end
        left--;
        case (mode)
          0:       out_tready = 1'b1;
          1:       out_tready = 1'($urandom_range(0, 1));
          2:       out_tready = ($urandom_range(0, 3) == 0);
          default: out_tready = ((left % 5) < 3);
        endcase
      end
    end
  end

  initial begin : stimulus
    int phase;
    int pr;
    int pc;
    int target;
    bit neg;
    phase_rows = '{1, 16, 0, 0, 7, 31, 17, 4, 3, 2, 16, 1, 8};
    phase_cols = '{1, 16, 0, 9, 0, 31, 4, 4, 8, 2, 1, 16, 8};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Every entry gets written once so that no later read sees an unwritten word.
    set_dims(16, 16);
    refill(1'b0);

    push(ACT_SYM,   16'h0000, 16'h0000, 32'h0);
    push(ACT_WRITE, 16'd0,    16'd0,    32'h7FFF_FFFF);
    push(ACT_WRITE, 16'd15,   16'd15,   32'h8000_0000);
    push(ACT_READ,  16'd0,    16'd0,    32'h0);
    push(ACT_READ,  16'd15,   16'd15,   32'hFFFF_FFFF);
    push(ACT_MAX,   16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    push(ACT_WRITE, 16'd0,    16'd1,    32'h1234_5678);
    push(ACT_SYM,   16'h0000, 16'h0000, 32'h0);
    push(ACT_READ,  16'hFFFF, 16'd0,    32'h0);
    push(ACT_READ,  16'd0,    16'd16,   32'h0);
    push(ACT_WRITE, 16'd16,   16'd0,    32'hDEAD_BEEF);
    push(ACT_WRITE, 16'h8000, 16'h7FFF, 32'h5555_5555);
    push(ACT_READ,  16'h7FFF, 16'h8000, 32'hAAAA_AAAA);

    set_dims(1, 1);
    push(ACT_WRITE, 16'd0, 16'd0, -32'sh1_8000);
    push(ACT_MAX,   16'd0, 16'd0, 32'h0);
    push(ACT_WRITE, 16'd0, 16'd0, -32'sh8000);
    push(ACT_MAX,   16'd0, 16'd0, 32'h0);
    push(ACT_WRITE, 16'd0, 16'd0, 32'h8000_0000);
    push(ACT_MAX,   16'd0, 16'd0, 32'h0);
    push(ACT_SYM,   16'd0, 16'd0, 32'h0);
    push(ACT_READ,  16'd0, 16'd1, 32'h0);

    set_dims(0, 0);
    push(ACT_SYM,   16'd0, 16'd0, 32'h0);
    push(ACT_MAX,   16'd0, 16'd0, 32'h0);
    push(ACT_WRITE, 16'd0, 16'd0, 32'h0001_0000);

    set_dims(2, 3);
    push(ACT_SYM,   16'd0, 16'd0, 32'h0);

    target = sent + RANDOM_ITEMS;
    phase = 0;
    while (sent < target) begin
      if (phase < 13) begin
        pr = phase_rows[phase];
        pc = phase_cols[phase];
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            pr = $urandom_range(0, 31);
            pc = $urandom_range(0, 31);
          end
          1, 2, 3: begin
            pr = $urandom_range(1, 8);
            pc = pr;
          end
          4: begin
            pr = 16;
            pc = 16;
          end
          default: begin
            pr = $urandom_range(1, 16);
            pc = $urandom_range(1, 16);
          end
        endcase
      end
      set_dims(pr, pc);
      neg = ($urandom_range(0, 3) == 0);
      if (nr * nc > 0 && nr * nc <= 64 && $urandom_range(0, 1) == 1) refill(neg);
      repeat ($urandom_range(60, 140)) random_item(neg);
      phase++;
    end

    idle(1);
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
rtl/msm_pkg.sv
rtl/msm_ram.sv
rtl/matrix_store_symmetry_max_core.sv
tb/msm_checker.sv
tb/tb.sv
